[rtl/alu8_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// alu8_pkg
// Shared types and constants for the 8-bit pipelined ALU.
// ----------------------------------------------------------------------------
package alu8_pkg;

   localparam int NUM_CELLS = 8;
   localparam int LATENCY   = NUM_CELLS + 2;

   typedef enum logic [2:0] {
      CMD_ADD  = 3'd0,
      CMD_SUB  = 3'd1,
      CMD_NEG  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_UDIV = 3'd4,
      CMD_SDIV = 3'd5,
      CMD_FMA  = 3'd6
   } cmd_type;

   localparam logic [2:0] CMD_UNUSED = 3'd7;

   typedef struct packed {
      logic       valid;
      logic       is_div;
      logic       flip;
      logic [7:0] num;
      logic [7:0] den;
      logic [8:0] part;
      logic [7:0] acc;
   } cell_data_type;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

[rtl/alu8_prep.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// alu8_prep
// Entry stage: computes the non-divide results and the divider operands.
// ----------------------------------------------------------------------------
module alu8_prep (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  wire  [2:0]             command,
   input  wire  [7:0]             operand_a,
   input  wire  [7:0]             operand_b,
   input  wire  [7:0]             operand_c,
   output alu8_pkg::cell_data_type data_out
);
   import alu8_pkg::*;

   cell_data_type data_ff;
   cell_data_type data_in;
   logic [15:0]   product;
   logic [7:0]    mag_a;
   logic [7:0]    mag_b;

   assign product = operand_a * operand_b;
   assign mag_a   = operand_a[7] ? 8'(-operand_a) : operand_a;
   assign mag_b   = operand_b[7] ? 8'(-operand_b) : operand_b;

   always_comb begin
      data_in        = '0;
      data_in.valid  = accept;
      case (cmd_type'(command))
         CMD_ADD: data_in.acc = operand_a + operand_b;
         CMD_SUB: data_in.acc = operand_a - operand_b;
         CMD_NEG: data_in.acc = 8'(-operand_a);
         CMD_MUL: data_in.acc = product[7:0];
         CMD_FMA: data_in.acc = product[7:0] + operand_c;
         CMD_UDIV: begin
            data_in.is_div = 1'b1;
            data_in.num    = operand_a;
            data_in.den    = operand_b;
         end
         CMD_SDIV: begin
            data_in.is_div = 1'b1;
            data_in.flip   = operand_a[7] ^ operand_b[7];
            data_in.num    = mag_a;
            data_in.den    = mag_b;
         end
         default: data_in.acc = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

[rtl/alu8_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// alu8_div_cell
// One restoring division step; other transactions pass through unchanged.
// ----------------------------------------------------------------------------
module alu8_div_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  alu8_pkg::cell_data_type data_in,
   output alu8_pkg::cell_data_type data_out
);
   import alu8_pkg::*;

   cell_data_type data_ff;
   cell_data_type step_in;
   logic [8:0]    shifted;
   logic [9:0]    diff;
   logic          fits;

   assign shifted = {data_in.part[7:0], data_in.num[7]};
   assign diff    = {1'b0, shifted} - {2'b00, data_in.den};
   assign fits    = ~diff[9];

   always_comb begin
      step_in = data_in;
      if (data_in.is_div) begin
         step_in.num  = {data_in.num[6:0], 1'b0};
         step_in.part = fits ? diff[8:0] : shifted;
         step_in.acc  = {data_in.acc[6:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= step_in;
      end
   end

   assign data_out = data_ff;

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

[rtl/alu_8bit_add_sub_mul_div_fma.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// alu_8bit_add_sub_mul_div_fma
// Pipelined 8-bit ALU: add, sub, neg, mul, unsigned and signed divide, fma.
// ----------------------------------------------------------------------------
// The block accepts one transaction in every clock cycle and marks its
// result with rsp_valid for one cycle. Each transaction passes through the
// entry stage, a chain of eight restoring divider cells that each produce
// one quotient bit, and the output register that applies the sign of a
// signed quotient. All commands take the same path, so results leave in
// the order the transactions came in. The receiver cannot stall the
// block; busy is high only while reset is asserted.
// ----------------------------------------------------------------------------
module alu_8bit_add_sub_mul_div_fma (
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   output logic       busy,
   input  wire  [2:0] req_command,
   input  wire  [7:0] req_operand_a,
   input  wire  [7:0] req_operand_b,
   input  wire  [7:0] req_operand_c,
   output logic       rsp_valid,
   output logic [7:0] rsp_result
);
   import alu8_pkg::*;

   cell_data_type chain [NUM_CELLS+1];
   logic          rsp_valid_ff;
   logic [7:0]    rsp_result_ff;
   logic [7:0]    rsp_result_in;
   cell_data_type last;

   assign busy = reset;

   alu8_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .accept    (start & ~busy),
      .command   (req_command),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .operand_c (req_operand_c),
      .data_out  (chain[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      alu8_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .data_in  (chain[i]),
         .data_out (chain[i+1])
      );
   end

   assign last          = chain[NUM_CELLS];
   assign rsp_result_in = last.flip ? 8'(-last.acc) : last.acc;

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

[rtl/alu8_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// alu8_checker
// Port-level checks on latency and selected results of the ALU.
// ----------------------------------------------------------------------------
module alu8_checker (
   input wire       clock,
   input wire       reset,
   input wire       start,
   input wire       busy,
   input wire [2:0] req_command,
   input wire [7:0] req_operand_a,
   input wire [7:0] req_operand_b,
   input wire       rsp_valid,
   input wire [7:0] rsp_result
);
   import alu8_pkg::*;

   logic accept;

   assign accept = start && !busy;

   a_not_busy: assert property (@(posedge clock) !reset |-> !busy)
      else $error("busy is high outside reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(accept, LATENCY))
      else $error("result strobe does not match an accepted transaction");

   a_add: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(accept && req_command == CMD_ADD, LATENCY)) |->
      rsp_result == 8'($past(req_operand_a, LATENCY) + $past(req_operand_b, LATENCY)))
      else $error("add result mismatch");

   a_udiv_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(accept && req_command == CMD_UDIV && req_operand_b == 8'd0,
                          LATENCY)) |-> rsp_result == 8'hFF)
      else $error("unsigned divide by zero does not give all ones");

   a_unused_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(accept && req_command == CMD_UNUSED, LATENCY)) |->
      rsp_result == 8'd0)
      else $error("unused command does not give zero");

endmodule

bind alu_8bit_add_sub_mul_div_fma alu8_checker u_alu8_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_command   (req_command),
   .req_operand_a (req_operand_a),
   .req_operand_b (req_operand_b),
   .rsp_valid     (rsp_valid),
   .rsp_result    (rsp_result)
);
// ----------------------------------------------------------------------------
`default_nettype wire
